// File: hdl/vmt_pkg.sv
// ----------------------------------------------------------------------------
// vmt_pkg
// Shared types and constants for the vertex matrix transform unit.
// ----------------------------------------------------------------------------
package vmt_pkg;

	localparam int SUM_W   = 67;
	localparam int ELEM_W  = 32;
	localparam int NUM_REGS = 8;
	localparam int REG_W   = 64;
	localparam int IDX_W   = 3;
	localparam int Q_W     = 32;
	localparam int ROW_LAT = 3;
	localparam int DIV_LAT = Q_W + 2;

	typedef enum logic {
		OP_POINT     = 1'b0,
		OP_DIRECTION = 1'b1
	} op_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] value;
		logic                     w_zero;
	} lane_res_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] m0;
		logic signed [ELEM_W-1:0] m1;
		logic signed [ELEM_W-1:0] m2;
		logic signed [ELEM_W-1:0] m3;
	} row_coef_t;

endpackage

// File: hdl/vertex_matrix_transform_unit.sv
// ----------------------------------------------------------------------------
// vertex_matrix_transform_unit
// 4x4 homogeneous transform of a 3D vector, with perspective divide for points.
// ----------------------------------------------------------------------------
// Takes one item every clock (busy stays low) and returns its result marked
// by done for one cycle; the receiver cannot stall. The pipeline holds three
// multiply/add stages per row lane and a 32-stage restoring divider per
// output lane. Matrix registers reset to identity and must only be written
// while no item is in flight.
module vertex_matrix_transform_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              cfg_we,
	input  logic [vmt_pkg::IDX_W-1:0]         cfg_index,
	input  logic [vmt_pkg::REG_W-1:0]         cfg_wdata,
	input  logic                              opcode,
	input  logic signed [vmt_pkg::ELEM_W-1:0] x_in,
	input  logic signed [vmt_pkg::ELEM_W-1:0] y_in,
	input  logic signed [vmt_pkg::ELEM_W-1:0] z_in,
	output logic                              done,
	output logic signed [vmt_pkg::ELEM_W-1:0] x_out,
	output logic signed [vmt_pkg::ELEM_W-1:0] y_out,
	output logic signed [vmt_pkg::ELEM_W-1:0] z_out,
	output logic                              w_zero
);

	localparam int LAT = 1 + vmt_pkg::ROW_LAT + vmt_pkg::DIV_LAT;
	localparam logic [vmt_pkg::ELEM_W-1:0] ONE = vmt_pkg::ELEM_W'(1) << FRAC_BITS;

	logic [vmt_pkg::REG_W-1:0]         mat_q [vmt_pkg::NUM_REGS];
	logic [LAT-1:0]                    vld_q;
	vmt_pkg::op_t                      op_s1;
	logic signed [vmt_pkg::ELEM_W-1:0] x_s1, y_s1, z_s1;
	logic                              pt_q [vmt_pkg::ROW_LAT];
	logic signed [vmt_pkg::SUM_W-1:0]  sum [4];
	vmt_pkg::lane_res_t                res [3];
	logic signed [vmt_pkg::ELEM_W-1:0] elem [16];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < vmt_pkg::NUM_REGS; i++) begin
				mat_q[i] <= '0;
			end
			mat_q[0] <= {32'd0, ONE};
			mat_q[2] <= {32'd0, 32'd0} | (vmt_pkg::REG_W'(ONE) << 32);
			mat_q[5] <= {32'd0, ONE};
			mat_q[7] <= vmt_pkg::REG_W'(ONE) << 32;
			vld_q    <= '0;
		end else begin
			if (cfg_we) begin
				mat_q[cfg_index] <= cfg_wdata;
			end
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= vmt_pkg::op_t'(opcode);
		x_s1  <= x_in;
		y_s1  <= y_in;
		z_s1  <= z_in;
		pt_q[0] <= op_s1 == vmt_pkg::OP_POINT;
		for (int i = 1; i < vmt_pkg::ROW_LAT; i++) begin
			pt_q[i] <= pt_q[i-1];
		end
	end

	for (genvar k = 0; k < 16; k++) begin : g_elem
		assign elem[k] = mat_q[k/2][(k%2)*32 +: 32];
	end

	for (genvar r = 0; r < 4; r++) begin : g_row
		vmt_pkg::row_coef_t coef;
		assign coef = '{m0: elem[r], m1: elem[r+4], m2: elem[r+8], m3: elem[r+12]};
		vmt_row_lane #(.FRAC_BITS(FRAC_BITS)) u_row (
			.clk    (clk),
			.coef   (coef),
			.opcode (op_s1),
			.x_in   (x_s1),
			.y_in   (y_s1),
			.z_in   (z_s1),
			.sum    (sum[r])
		);
	end

	for (genvar r = 0; r < 3; r++) begin : g_div
		vmt_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div (
			.clk   (clk),
			.point (pt_q[vmt_pkg::ROW_LAT-1]),
			.num   (sum[r]),
			.den   (sum[3]),
			.res   (res[r])
		);
	end

	assign done   = vld_q[LAT-1];
	assign x_out  = res[0].value;
	assign y_out  = res[1].value;
	assign z_out  = res[2].value;
	assign w_zero = res[0].w_zero;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done) else $error("item result not delivered on time");

	a_wzero_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(done && w_zero) |-> (x_out == '0 && y_out == '0 && z_out == '0))
		else $error("zero w with nonzero outputs");

	a_lanes_agree: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (res[0].w_zero == res[1].w_zero && res[1].w_zero == res[2].w_zero))
		else $error("lanes disagree on zero w");

endmodule

// File: hdl/vmt_row_lane.sv
// ----------------------------------------------------------------------------
// vmt_row_lane
// One matrix row: three products, translation term and exact row sum.
// ----------------------------------------------------------------------------
module vmt_row_lane #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  vmt_pkg::row_coef_t                coef,
	input  vmt_pkg::op_t                      opcode,
	input  logic signed [vmt_pkg::ELEM_W-1:0] x_in,
	input  logic signed [vmt_pkg::ELEM_W-1:0] y_in,
	input  logic signed [vmt_pkg::ELEM_W-1:0] z_in,
	output logic signed [vmt_pkg::SUM_W-1:0]  sum
);

	localparam int PW = 2 * vmt_pkg::ELEM_W;

	logic signed [PW-1:0]             px_s1, py_s1, pz_s1;
	logic signed [vmt_pkg::SUM_W-1:0] tr_s1;
	logic signed [vmt_pkg::SUM_W-1:0] a_s2, b_s2;
	logic signed [vmt_pkg::SUM_W-1:0] tr_c;

	always_comb begin
		tr_c = $signed({{(vmt_pkg::SUM_W-vmt_pkg::ELEM_W){coef.m3[vmt_pkg::ELEM_W-1]}},
			coef.m3}) <<< FRAC_BITS;
		if (opcode != vmt_pkg::OP_POINT) begin
			tr_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= coef.m0 * x_in;
		py_s1 <= coef.m1 * y_in;
		pz_s1 <= coef.m2 * z_in;
		tr_s1 <= tr_c;
		a_s2  <= vmt_pkg::SUM_W'(px_s1) + vmt_pkg::SUM_W'(py_s1);
		b_s2  <= vmt_pkg::SUM_W'(pz_s1) + tr_s1;
		sum   <= a_s2 + b_s2;
	end

endmodule

// File: hdl/vmt_div_lane.sv
// ----------------------------------------------------------------------------
// vmt_div_lane
// Output lane: scale and saturate, or pipelined restoring divide by w.
// ----------------------------------------------------------------------------
module vmt_div_lane #(
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             point,
	input  logic signed [vmt_pkg::SUM_W-1:0] num,
	input  logic signed [vmt_pkg::SUM_W-1:0] den,
	output vmt_pkg::lane_res_t               res
);

	localparam int SW = vmt_pkg::SUM_W;
	localparam int QW = vmt_pkg::Q_W;
	localparam int NW = SW + FRAC_BITS;

	logic [SW-1:0]                n_c, d_c;
	logic [NW-1:0]                nsh_c;
	logic [NW-QW-1:0]             hi_c;
	logic signed [SW-1:0]         sc_c;
	logic signed [QW-1:0]         dir_c;

	logic [SW-1:0]                rem_s  [QW+1];
	logic [SW-1:0]                d_s    [QW+1];
	logic [QW-1:0]                lo_s   [QW+1];
	logic [QW-1:0]                q_s    [QW+1];
	logic                         over_s [QW+1];
	logic                         neg_s  [QW+1];
	logic                         wz_s   [QW+1];
	logic                         pt_s   [QW+1];
	logic signed [QW-1:0]         dir_s  [QW+1];

	always_comb begin
		n_c   = num[SW-1] ? SW'(-num) : SW'(num);
		d_c   = den[SW-1] ? SW'(-den) : SW'(den);
		nsh_c = {n_c, {FRAC_BITS{1'b0}}};
		hi_c  = nsh_c[NW-1:QW];
		sc_c  = num >>> FRAC_BITS;
		if (sc_c > SW'(32'sh7FFF_FFFF)) begin
			dir_c = 32'sh7FFF_FFFF;
		end else if (sc_c < -(SW'(33'sh0_8000_0000))) begin
			dir_c = 32'sh8000_0000;
		end else begin
			dir_c = sc_c[QW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= SW'(hi_c);
		d_s[0]    <= d_c;
		lo_s[0]   <= nsh_c[QW-1:0];
		q_s[0]    <= '0;
		over_s[0] <= SW'(hi_c) >= d_c;
		neg_s[0]  <= num[SW-1] ^ den[SW-1];
		wz_s[0]   <= d_c == '0;
		pt_s[0]   <= point;
		dir_s[0]  <= dir_c;
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [SW:0] t;
		logic        ge;
		always_comb begin
			t  = {rem_s[k], lo_s[k][QW-1]};
			ge = t >= {1'b0, d_s[k]};
		end
		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? SW'(t - {1'b0, d_s[k]}) : SW'(t);
			d_s[k+1]    <= d_s[k];
			lo_s[k+1]   <= {lo_s[k][QW-2:0], 1'b0};
			q_s[k+1]    <= {q_s[k][QW-2:0], ge};
			over_s[k+1] <= over_s[k];
			neg_s[k+1]  <= neg_s[k];
			wz_s[k+1]   <= wz_s[k];
			pt_s[k+1]   <= pt_s[k];
			dir_s[k+1]  <= dir_s[k];
		end
	end

	always_ff @(posedge clk) begin
		res.w_zero <= pt_s[QW] && wz_s[QW];
		if (!pt_s[QW]) begin
			res.value <= dir_s[QW];
		end else if (wz_s[QW]) begin
			res.value <= '0;
		end else if (!neg_s[QW]) begin
			res.value <= (over_s[QW] || q_s[QW] > 32'h7FFF_FFFF) ?
				32'sh7FFF_FFFF : $signed(q_s[QW]);
		end else begin
			res.value <= (over_s[QW] || q_s[QW] > 32'h8000_0000) ?
				32'sh8000_0000 : $signed(32'(0) - q_s[QW]);
		end
	end

endmodule

// File: sim/vertex_matrix_transform_unit_test.sv
// ----------------------------------------------------------------------------
// vertex_matrix_transform_unit_test
// Drives points and directions through the transform unit under a series of
// matrices (identity, random, extreme, singular and perspective) and compares
// every result with a fixed-point prediction kept by a small scoreboard.
// ----------------------------------------------------------------------------
module vertex_matrix_transform_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam int PHASE_ITEMS = 250;
	localparam int NUM_PHASES = 8;
	localparam int DRAIN_CYCLES = 50;
	localparam int CYCLE_LIMIT = 500000;

	typedef struct {
		logic signed [vmt_pkg::ELEM_W-1:0] x;
		logic signed [vmt_pkg::ELEM_W-1:0] y;
		logic signed [vmt_pkg::ELEM_W-1:0] z;
		logic                              wz;
	} vec_res_t;

	class transform_scoreboard;
		logic signed [vmt_pkg::ELEM_W-1:0] m[16];
		vec_res_t pending_q[$];
		int errors;
		int n_point;
		int n_dir;
		int n_wzero;

		function void set_reg(int idx, logic [vmt_pkg::REG_W-1:0] val);
			m[2*idx]   = val[31:0];
			m[2*idx+1] = val[63:32];
		endfunction

		function logic signed [127:0] row_sum(int r, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z, bit trans);
			logic signed [127:0] s;
			logic signed [127:0] t;
			s = m[r] * x + m[r+4] * y + m[r+8] * z;
			t = m[r+12];
			if (trans) s = s + (t <<< FRAC);
			return s;
		endfunction

		function logic signed [31:0] clamp(logic signed [127:0] v);
			logic signed [127:0] hi;
			logic signed [127:0] lo;
			hi = 128'sh7FFFFFFF;
			lo = -128'sh80000000;
			if (v > hi) return 32'h7FFFFFFF;
			if (v < lo) return 32'h80000000;
			return v[31:0];
		endfunction

		function logic signed [31:0] quotient(logic signed [127:0] num,
			logic signed [127:0] den);
			logic [127:0] n;
			logic [127:0] d;
			logic [127:0] q;
			bit neg;
			neg = (num < 0) != (den < 0);
			n = (num < 0) ? -num : num;
			d = (den < 0) ? -den : den;
			q = (n << FRAC) / d;
			if (!neg) return (q > 128'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
			if (q > 128'h80000000) return 32'h80000000;
			return -q[31:0];
		endfunction

		function void note_item(vmt_pkg::op_t op, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z);
			vec_res_t e;
			logic signed [127:0] w;
			e.wz = 1'b0;
			if (op == vmt_pkg::OP_DIRECTION) begin
				n_dir++;
				e.x = clamp(row_sum(0, x, y, z, 0) >>> FRAC);
				e.y = clamp(row_sum(1, x, y, z, 0) >>> FRAC);
				e.z = clamp(row_sum(2, x, y, z, 0) >>> FRAC);
			end else begin
				n_point++;
				w = row_sum(3, x, y, z, 1);
				if (w == 0) begin
					n_wzero++;
					e.x = '0;
					e.y = '0;
					e.z = '0;
					e.wz = 1'b1;
				end else begin
					e.x = quotient(row_sum(0, x, y, z, 1), w);
					e.y = quotient(row_sum(1, x, y, z, 1), w);
					e.z = quotient(row_sum(2, x, y, z, 1), w);
				end
			end
			pending_q.push_back(e);
		endfunction

		function void check_result(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic wz);
			vec_res_t e;
			if (pending_q.size() == 0) begin
				$error("unexpected result x=%h y=%h z=%h w_zero=%b", x, y, z, wz);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (x !== e.x) begin
				$error("x_out expected %h got %h", e.x, x);
				errors++;
			end
			if (y !== e.y) begin
				$error("y_out expected %h got %h", e.y, y);
				errors++;
			end
			if (z !== e.z) begin
				$error("z_out expected %h got %h", e.z, z);
				errors++;
			end
			if (wz !== e.wz) begin
				$error("w_zero expected %b got %b", e.wz, wz);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cfg_we = 1'b0;
	logic [vmt_pkg::IDX_W-1:0] cfg_index = '0;
	logic [vmt_pkg::REG_W-1:0] cfg_wdata = '0;
	logic opcode = 1'b0;
	logic signed [vmt_pkg::ELEM_W-1:0] x_in = '0;
	logic signed [vmt_pkg::ELEM_W-1:0] y_in = '0;
	logic signed [vmt_pkg::ELEM_W-1:0] z_in = '0;
	logic done;
	logic signed [vmt_pkg::ELEM_W-1:0] x_out;
	logic signed [vmt_pkg::ELEM_W-1:0] y_out;
	logic signed [vmt_pkg::ELEM_W-1:0] z_out;
	logic w_zero;

	transform_scoreboard sb = new();
	int cycles = 0;

	vertex_matrix_transform_unit #(.FRAC_BITS(FRAC)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.opcode(opcode), .x_in(x_in), .y_in(y_in), .z_in(z_in),
		.done(done), .x_out(x_out), .y_out(y_out), .z_out(z_out), .w_zero(w_zero)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[vertex_matrix_transform_unit] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (done) sb.check_result(x_out, y_out, z_out, w_zero);
	end

	function logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'h7FFFFFFF - $urandom_range(0, 2);
			2: return 32'h80000000 + $urandom_range(0, 2);
			3: return $urandom_range(0, 4) - 2;
			default: return $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
		endcase
	endfunction

	function logic [31:0] rand_coef(int kind);
		case (kind)
			1: return $urandom();
			2: return 32'h7FFFFFFF;
			3: return 32'h80000000;
			6: return 32'h0;
			default: return ($urandom_range(0, 3) == 0) ? 32'h0 :
				$urandom_range(0, 32'h0007FFFF) - 32'h00040000;
		endcase
	endfunction

	task automatic write_matrix(int kind);
		logic [31:0] e[16];
		for (int k = 0; k < 16; k++) e[k] = rand_coef(kind);
		if (kind == 4) begin
			e[3] = '0; e[7] = '0; e[11] = '0; e[15] = '0;
		end
		if (kind == 5) begin
			e[3] = '0; e[7] = '0; e[11] = 32'h00010000; e[15] = '0;
		end
		for (int i = 0; i < vmt_pkg::NUM_REGS; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= i[vmt_pkg::IDX_W-1:0];
			cfg_wdata <= {e[2*i+1], e[2*i]};
			sb.set_reg(i, {e[2*i+1], e[2*i]});
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic send_item(vmt_pkg::op_t op, logic [31:0] x, logic [31:0] y,
		logic [31:0] z);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		x_in <= x;
		y_in <= y;
		z_in <= z;
		do @(posedge clk); while (busy);
		sb.note_item(op, x, y, z);
	endtask

	task automatic settle();
		start <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [31:0] ext[4];
		vmt_pkg::op_t op;
		for (int i = 0; i < vmt_pkg::NUM_REGS; i++) begin
			sb.set_reg(i, (i == 0 || i == 5) ? 64'd65536 :
				(i == 2 || i == 7) ? 64'd281474976710656 : 64'd0);
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		ext = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF};
		for (int i = 0; i < 4; i++) begin
			send_item(vmt_pkg::OP_POINT, ext[i], ext[(i+1)%4], ext[(i+2)%4]);
			send_item(vmt_pkg::OP_DIRECTION, ext[i], ext[(i+1)%4], ext[(i+2)%4]);
		end
		send_item(vmt_pkg::OP_POINT, 32'h00018000, 32'hFFFE8000, 32'h00000001);
		send_item(vmt_pkg::OP_DIRECTION, 32'h00018000, 32'hFFFE8000, 32'h00000001);
		settle();
		write_matrix(4);
		send_item(vmt_pkg::OP_POINT, 32'h00010000, 32'h00020000, 32'h00030000);
		send_item(vmt_pkg::OP_DIRECTION, 32'h00010000, 32'h00020000, 32'h00030000);
		settle();
		write_matrix(5);
		send_item(vmt_pkg::OP_POINT, 32'h00010000, 32'h00010000, 32'h0);
		send_item(vmt_pkg::OP_POINT, 32'h00010000, 32'h00010000, 32'hFFFFFFFF);
		send_item(vmt_pkg::OP_POINT, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00000001);
		settle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_matrix((p == NUM_PHASES - 1) ? 0 : p);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				op = ($urandom_range(0, 1) == 1) ? vmt_pkg::OP_DIRECTION :
					vmt_pkg::OP_POINT;
				if ($urandom_range(0, 7) == 0) send_item(op, rand_value(), rand_value(), 32'h0);
				else send_item(op, rand_value(), rand_value(), rand_value());
			end
			settle();
		end

		$display("covered %0d point and %0d direction items, %0d with zero w",
			sb.n_point, sb.n_dir, sb.n_wzero);
		$display("matrices: identity, random, saturated, singular and perspective");
		if (sb.errors == 0) begin
			$display("[vertex_matrix_transform_unit] OK");
		end else begin
			$display("[vertex_matrix_transform_unit] ERROR");
		end
		$finish;
	end

endmodule

// File: files.f
hdl/vmt_pkg.sv
hdl/vmt_row_lane.sv
hdl/vmt_div_lane.sv
hdl/vertex_matrix_transform_unit.sv
sim/vertex_matrix_transform_unit_test.sv
